[hdl/usbreq_pkg.sv]
// Shared types, request codes and sizing constants of the USB standard request handler.
package usbreq_pkg;

   // Sizing of the device model.
   localparam int NUM_STRINGS   = 4;
   localparam int NUM_LANGS     = 2;
   localparam int NUM_ENDPOINTS = 16;
   localparam int EP_W          = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;
   localparam int MASK_W        = 8;
   localparam int BYTE_W        = 8;

   // Stream widths.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_LANG_COUNT   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LANG_FIRST   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LANG_SECOND  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_STRING_MASK  = 2'd3;

   // Descriptor types, feature selector and request types.
   localparam logic [7:0] DESC_DEVICE        = 8'd1;
   localparam logic [7:0] DESC_CONFIG        = 8'd2;
   localparam logic [7:0] DESC_STRING        = 8'd3;
   localparam logic [7:0] FEATURE_EP_HALT    = 8'd0;
   localparam logic [7:0] RECIP_DEVICE_IN    = 8'h80;
   localparam logic [7:0] RECIP_INTERFACE_IN = 8'h81;
   localparam logic [7:0] RECIP_ENDPOINT_IN  = 8'h82;

   // Standard request codes.
   localparam logic [7:0] RQ_GET_STATUS     = 8'd0;
   localparam logic [7:0] RQ_CLEAR_FEATURE  = 8'd1;
   localparam logic [7:0] RQ_SET_FEATURE    = 8'd3;
   localparam logic [7:0] RQ_GET_DESCRIPTOR = 8'd6;
   localparam logic [7:0] RQ_GET_CONFIG     = 8'd8;
   localparam logic [7:0] RQ_SET_CONFIG     = 8'd9;
   localparam logic [7:0] RQ_GET_INTERFACE  = 8'd10;
   localparam logic [7:0] RQ_SET_INTERFACE  = 8'd11;

   // Result actions.
   localparam logic [1:0] ACT_ACK   = 2'd0;
   localparam logic [1:0] ACT_DATA  = 2'd1;
   localparam logic [1:0] ACT_DESC  = 2'd2;
   localparam logic [1:0] ACT_STALL = 2'd3;

   // Descriptor kinds.
   localparam logic [1:0] KIND_DEVICE = 2'd0;
   localparam logic [1:0] KIND_CONFIG = 2'd1;
   localparam logic [1:0] KIND_STRING = 2'd2;

   typedef struct packed {
      logic [7:0]  recipient_type;
      logic [7:0]  req_type;
      logic [15:0] setup_value;
      logic [15:0] setup_index;
   } setup_type;

   typedef struct packed {
      logic [1:0] action;
      logic [1:0] byte_count;
      logic [7:0] data_first;
      logic [7:0] data_second;
      logic [1:0] descriptor_kind;
      logic       string_lang;
      logic [1:0] string_number;
   } result_type;

   typedef struct packed {
      logic [1:0]        lang_count;
      logic [15:0]       lang_id_first;
      logic [15:0]       lang_id_second;
      logic [MASK_W-1:0] string_present_mask;
   } csr_type;

   typedef struct packed {
      logic [BYTE_W-1:0]        config_value;
      logic [BYTE_W-1:0]        alt_value;
      logic [NUM_ENDPOINTS-1:0] endpoint_halt;
   } dev_state_type;

   typedef struct packed {
      logic              config_we;
      logic              alt_we;
      logic [BYTE_W-1:0] new_value;
      logic              halt_we;
      logic [EP_W-1:0]   halt_ep;
      logic              halt_set;
   } state_update_type;

endpackage

[hdl/usb_standard_request_handler.sv]
// Top level of the USB standard request handler: stream ports, pipeline registers.
// An accepted setup item is decoded while it sits in the input register, and its result
// item is offered from the result register, which holds it while the receiver stalls.
// Throughput: one item per cycle unless the receiver stalls; input and result registers
// are the only stages, with a single pass of shallow compare logic between them.
// Reset is synchronous and active high: it empties both stages, returns configuration,
// alternate setting and halt bits to zero and the configuration registers to defaults.
module usb_standard_request_handler (
   input  logic                              clock,
   input  logic                              reset,
   // Setup items. Fields from bit 0 up: recipient_type[7:0], req_type[15:8],
   // setup_value[31:16], setup_index[47:32].
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [usbreq_pkg::REQ_DATA_W-1:0] req_tdata,
   // Result items. Fields from bit 0 up: action[1:0], byte_count[3:2],
   // data_first[11:4], data_second[19:12], descriptor_kind[21:20], string_lang[22],
   // string_number[24:23], zero fill[31:25].
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [usbreq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Configuration write port.
   input  logic                              csr_we,
   input  logic [usbreq_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [usbreq_pkg::CSR_DATA_W-1:0] csr_wdata
);

   usbreq_pkg::setup_type        setup_ff, setup_in;
   logic                         setup_valid_ff, setup_valid_in;
   usbreq_pkg::result_type       result_ff, result_in;
   logic                         result_valid_ff, result_valid_in;
   usbreq_pkg::result_type       result_comb;
   usbreq_pkg::state_update_type update;
   usbreq_pkg::dev_state_type    dev_state;
   usbreq_pkg::csr_type          csr;
   logic                         advance;
   logic                         req_fire;

   // The result register is free when empty or when its item leaves this cycle.
   assign advance    = setup_valid_ff && (!result_valid_ff || rsp_tready);
   assign req_tready = !setup_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   usbreq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .csr_out   (csr)
   );

   usbreq_decode u_decode (
      .setup     (setup_ff),
      .dev_state (dev_state),
      .csr       (csr),
      .result    (result_comb),
      .update    (update)
   );

   // The device state changes only as the item moves on, which keeps items in order.
   usbreq_state u_state (
      .clock     (clock),
      .reset     (reset),
      .update_en (advance),
      .update    (update),
      .dev_state (dev_state)
   );

   always_comb begin
      setup_in       = setup_ff;
      setup_valid_in = setup_valid_ff;
      if (req_fire) begin
         setup_in.recipient_type = req_tdata[7:0];
         setup_in.req_type       = req_tdata[15:8];
         setup_in.setup_value    = req_tdata[31:16];
         setup_in.setup_index    = req_tdata[47:32];
         setup_valid_in          = 1'b1;
      end else if (advance) begin
         setup_valid_in = 1'b0;
      end

      result_in       = result_ff;
      result_valid_in = result_valid_ff;
      if (advance) begin
         result_in       = result_comb;
         result_valid_in = 1'b1;
      end else if (rsp_tready) begin
         result_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_valid_ff  <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         setup_valid_ff  <= setup_valid_in;
         result_valid_ff <= result_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      setup_ff  <= setup_in;
      result_ff <= result_in;
   end

   assign rsp_tvalid = result_valid_ff;
   assign rsp_tdata  = {7'd0,
                        result_ff.string_number,
                        result_ff.string_lang,
                        result_ff.descriptor_kind,
                        result_ff.data_second,
                        result_ff.data_first,
                        result_ff.byte_count,
                        result_ff.action};

endmodule

[hdl/usbreq_csr.sv]
// Configuration registers: language count, language IDs and string presence mask.
module usbreq_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [usbreq_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [usbreq_pkg::CSR_DATA_W-1:0] csr_wdata,
   output usbreq_pkg::csr_type               csr_out
);

   usbreq_pkg::csr_type csr_ff, csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_addr)
            usbreq_pkg::CSR_LANG_COUNT:  csr_in.lang_count     = csr_wdata[1:0];
            usbreq_pkg::CSR_LANG_FIRST:  csr_in.lang_id_first  = csr_wdata;
            usbreq_pkg::CSR_LANG_SECOND: csr_in.lang_id_second = csr_wdata;
            usbreq_pkg::CSR_STRING_MASK:
               csr_in.string_present_mask = csr_wdata[usbreq_pkg::MASK_W-1:0];
            default: csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.lang_count          <= 2'd1;
         csr_ff.lang_id_first       <= 16'd1033;
         csr_ff.lang_id_second      <= 16'd0;
         csr_ff.string_present_mask <= {usbreq_pkg::MASK_W{1'b1}};
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr_out = csr_ff;

endmodule

[hdl/usbreq_state.sv]
// Device state: current configuration, alternate setting and endpoint halt bits.
module usbreq_state (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         update_en,
   input  usbreq_pkg::state_update_type update,
   output usbreq_pkg::dev_state_type    dev_state
);

   usbreq_pkg::dev_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      if (update_en) begin
         if (update.config_we) begin
            state_in.config_value = update.new_value;
         end
         if (update.alt_we) begin
            state_in.alt_value = update.new_value;
         end
         if (update.halt_we) begin
            state_in.endpoint_halt[update.halt_ep] = update.halt_set;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign dev_state = state_ff;

endmodule

[hdl/usbreq_decode.sv]
// Decodes one setup packet into a result and a device state update.
module usbreq_decode (
   input  usbreq_pkg::setup_type        setup,
   input  usbreq_pkg::dev_state_type    dev_state,
   input  usbreq_pkg::csr_type          csr,
   output usbreq_pkg::result_type       result,
   output usbreq_pkg::state_update_type update
);

   logic [7:0] desc_type;
   logic [7:0] desc_num;
   logic [7:0] ep;
   logic       ep_ok;
   logic       lang_hit;
   logic       slot;
   logic [7:0] bit_pos;
   logic       string_ok;

   assign desc_type = setup.setup_value[15:8];
   assign desc_num  = setup.setup_value[7:0];
   assign ep        = setup.setup_index[7:0];
   assign ep_ok     = ep < 8'(usbreq_pkg::NUM_ENDPOINTS);

   // Language slot search; a count of three behaves as two.
   always_comb begin
      lang_hit = 1'b0;
      slot     = 1'b0;
      if (csr.lang_count != 2'd0 && setup.setup_index == csr.lang_id_first) begin
         lang_hit = 1'b1;
      end else if (csr.lang_count[1] && setup.setup_index == csr.lang_id_second) begin
         lang_hit = 1'b1;
         slot     = 1'b1;
      end
   end

   assign bit_pos = {5'd0, slot, 2'b00} + desc_num;

   assign string_ok = lang_hit
                   && (desc_num < 8'(usbreq_pkg::NUM_STRINGS))
                   && ({7'd0, slot} < 8'(usbreq_pkg::NUM_LANGS))
                   && (bit_pos < 8'(usbreq_pkg::MASK_W))
                   && csr.string_present_mask[bit_pos[2:0]];

   always_comb begin
      result           = '0;
      result.action    = usbreq_pkg::ACT_ACK;
      update           = '0;
      update.new_value = desc_num;
      update.halt_ep   = ep[usbreq_pkg::EP_W-1:0];
      update.halt_set  = (setup.req_type == usbreq_pkg::RQ_SET_FEATURE);

      case (setup.req_type)
         usbreq_pkg::RQ_GET_DESCRIPTOR: begin
            if (desc_type == usbreq_pkg::DESC_DEVICE) begin
               result.action          = usbreq_pkg::ACT_DESC;
               result.descriptor_kind = usbreq_pkg::KIND_DEVICE;
            end else if (desc_type == usbreq_pkg::DESC_CONFIG) begin
               result.action          = usbreq_pkg::ACT_DESC;
               result.descriptor_kind = usbreq_pkg::KIND_CONFIG;
            end else if (desc_type == usbreq_pkg::DESC_STRING
                         && (desc_num == 8'd0 || string_ok)) begin
               // String zero always takes language slot zero.
               result.action          = usbreq_pkg::ACT_DESC;
               result.descriptor_kind = usbreq_pkg::KIND_STRING;
               result.string_lang     = (desc_num == 8'd0) ? 1'b0 : slot;
               result.string_number   = desc_num[1:0];
            end else begin
               result.action = usbreq_pkg::ACT_STALL;
            end
         end
         usbreq_pkg::RQ_GET_INTERFACE: begin
            result.action     = usbreq_pkg::ACT_DATA;
            result.byte_count = 2'd1;
            result.data_first = dev_state.alt_value;
         end
         usbreq_pkg::RQ_SET_INTERFACE: begin
            update.alt_we = 1'b1;
         end
         usbreq_pkg::RQ_SET_CONFIG: begin
            update.config_we = 1'b1;
         end
         usbreq_pkg::RQ_GET_CONFIG: begin
            result.action     = usbreq_pkg::ACT_DATA;
            result.byte_count = 2'd1;
            result.data_first = dev_state.config_value;
         end
         usbreq_pkg::RQ_GET_STATUS: begin
            if (setup.recipient_type == usbreq_pkg::RECIP_DEVICE_IN
                || setup.recipient_type == usbreq_pkg::RECIP_INTERFACE_IN) begin
               result.action     = usbreq_pkg::ACT_DATA;
               result.byte_count = 2'd2;
            end else if (setup.recipient_type == usbreq_pkg::RECIP_ENDPOINT_IN) begin
               result.action     = usbreq_pkg::ACT_DATA;
               result.byte_count = 2'd2;
               result.data_first = {7'd0, ep_ok
                  && dev_state.endpoint_halt[ep[usbreq_pkg::EP_W-1:0]]};
            end
         end
         usbreq_pkg::RQ_SET_FEATURE, usbreq_pkg::RQ_CLEAR_FEATURE: begin
            if (desc_num != usbreq_pkg::FEATURE_EP_HALT) begin
               result.action = usbreq_pkg::ACT_STALL;
            end else begin
               update.halt_we = ep_ok;
            end
         end
         default: begin
            result.action = usbreq_pkg::ACT_ACK;
         end
      endcase
   end

endmodule

[sim/testbench.sv]
// Self-checking testbench for the USB standard request handler.
`timescale 1ns / 1ps

module testbench;

   // One step of the directed plan: either a register write or a setup item. Where the
   // answer can be read off directly it is pinned in the row; otherwise the device
   // model below works it out.
   typedef struct {
      bit                                is_write;
      logic [usbreq_pkg::CSR_ADDR_W-1:0] reg_idx;
      logic [usbreq_pkg::CSR_DATA_W-1:0] reg_val;
      usbreq_pkg::setup_type             pkt;
      bit                                pinned;
      usbreq_pkg::result_type            want;
   } plan_row_type;

   // Travels alongside each offered setup item, so that the scoreboard knows whether
   // the answer was pinned by the plan.
   typedef struct {
      bit                     pinned;
      usbreq_pkg::result_type want;
   } answer_note_type;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [usbreq_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [usbreq_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                              csr_we;
   logic [usbreq_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [usbreq_pkg::CSR_DATA_W-1:0] csr_wdata;

   // Device model: our own copy of the configuration registers and of the
   // configuration value, alternate setting and endpoint halt bits.
   logic [1:0]                           cfg_lang_count;
   logic [15:0]                          cfg_lang_first;
   logic [15:0]                          cfg_lang_second;
   logic [usbreq_pkg::MASK_W-1:0]        cfg_string_mask;
   logic [7:0]                           dev_config;
   logic [7:0]                           dev_alt;
   logic [usbreq_pkg::NUM_ENDPOINTS-1:0] ep_halted;

   answer_note_type        notes_q[$];
   usbreq_pkg::result_type answers_due[$];
   plan_row_type           plan[$];
   int                     items_sent;
   int                     results_seen;
   bit                     run_failed;

   // Knobs for the sender and the receiver: no idling at all, and a single long
   // hold-off of the result channel.
   bit steady_sender;
   bit steady_receiver;
   bit hold_off_request;

   usb_standard_request_handler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Works out the answer to one setup packet and applies its side effects to the
   // device model. Anything left unused in the answer stays zero, and a stall clears
   // every field apart from the action.
   function automatic usbreq_pkg::result_type predict_answer(
         input usbreq_pkg::setup_type s);
      usbreq_pkg::result_type r;
      logic [7:0] ep;
      logic [7:0] dtype;
      logic [7:0] snum;
      int         n_langs;
      int         slot;
      int         bitpos;
      bit         found;
      r     = '0;
      ep    = s.setup_index[7:0];
      dtype = s.setup_value[15:8];
      snum  = s.setup_value[7:0];
      case (s.req_type)
         usbreq_pkg::RQ_GET_DESCRIPTOR: begin
            if (dtype == usbreq_pkg::DESC_DEVICE) begin
               r.action          = usbreq_pkg::ACT_DESC;
               r.descriptor_kind = usbreq_pkg::KIND_DEVICE;
            end else if (dtype == usbreq_pkg::DESC_CONFIG) begin
               r.action          = usbreq_pkg::ACT_DESC;
               r.descriptor_kind = usbreq_pkg::KIND_CONFIG;
            end else if (dtype != usbreq_pkg::DESC_STRING) begin
               r.action = usbreq_pkg::ACT_STALL;
            end else begin
               // String zero needs neither a language match nor a presence bit.
               slot  = 0;
               found = 1'b1;
               if (snum != 0) begin
                  // A count of three only ever means the two IDs that exist.
                  n_langs = (cfg_lang_count > 2) ? 2 : int'(cfg_lang_count);
                  if (n_langs >= 1 && s.setup_index == cfg_lang_first)
                     slot = 0;
                  else if (n_langs >= 2 && s.setup_index == cfg_lang_second)
                     slot = 1;
                  else
                     found = 1'b0;
                  if (found && (snum >= usbreq_pkg::NUM_STRINGS
                                || slot >= usbreq_pkg::NUM_LANGS))
                     found = 1'b0;
                  if (found) begin
                     bitpos = slot * 4 + snum;
                     if (bitpos >= usbreq_pkg::MASK_W || !cfg_string_mask[bitpos])
                        found = 1'b0;
                  end
               end
               if (found) begin
                  r.action          = usbreq_pkg::ACT_DESC;
                  r.descriptor_kind = usbreq_pkg::KIND_STRING;
                  r.string_lang     = slot[0];
                  r.string_number   = snum[1:0];
               end else begin
                  r.action = usbreq_pkg::ACT_STALL;
               end
            end
         end
         usbreq_pkg::RQ_GET_INTERFACE: begin
            r.action     = usbreq_pkg::ACT_DATA;
            r.byte_count = 2'd1;
            r.data_first = dev_alt;
         end
         usbreq_pkg::RQ_SET_INTERFACE: dev_alt = s.setup_value[7:0];
         usbreq_pkg::RQ_SET_CONFIG:    dev_config = s.setup_value[7:0];
         usbreq_pkg::RQ_GET_CONFIG: begin
            r.action     = usbreq_pkg::ACT_DATA;
            r.byte_count = 2'd1;
            r.data_first = dev_config;
         end
         usbreq_pkg::RQ_GET_STATUS: begin
            // Any other recipient is simply acknowledged without data.
            if (s.recipient_type == usbreq_pkg::RECIP_DEVICE_IN
                || s.recipient_type == usbreq_pkg::RECIP_INTERFACE_IN) begin
               r.action     = usbreq_pkg::ACT_DATA;
               r.byte_count = 2'd2;
            end else if (s.recipient_type == usbreq_pkg::RECIP_ENDPOINT_IN) begin
               r.action     = usbreq_pkg::ACT_DATA;
               r.byte_count = 2'd2;
               if (ep < usbreq_pkg::NUM_ENDPOINTS)
                  r.data_first = {7'd0, ep_halted[ep[usbreq_pkg::EP_W-1:0]]};
            end
         end
         usbreq_pkg::RQ_SET_FEATURE, usbreq_pkg::RQ_CLEAR_FEATURE: begin
            // Only the endpoint halt selector is supported; the recipient is not
            // looked at, and an endpoint out of range is acknowledged but ignored.
            if (s.setup_value[7:0] != usbreq_pkg::FEATURE_EP_HALT)
               r.action = usbreq_pkg::ACT_STALL;
            else if (ep < usbreq_pkg::NUM_ENDPOINTS)
               ep_halted[ep[usbreq_pkg::EP_W-1:0]] =
                  (s.req_type == usbreq_pkg::RQ_SET_FEATURE);
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic usbreq_pkg::setup_type make_setup(
         input logic [7:0] rt, input logic [7:0] rq,
         input logic [15:0] val, input logic [15:0] idx);
      usbreq_pkg::setup_type s;
      s.recipient_type = rt;
      s.req_type       = rq;
      s.setup_value    = val;
      s.setup_index    = idx;
      return s;
   endfunction

   function automatic usbreq_pkg::result_type plain_answer(
         input logic [1:0] act, input logic [1:0] cnt, input logic [1:0] kind);
      usbreq_pkg::result_type r;
      r                 = '0;
      r.action          = act;
      r.byte_count      = cnt;
      r.descriptor_kind = kind;
      return r;
   endfunction

   function automatic void plan_setup(input logic [7:0] rt, input logic [7:0] rq,
                                      input logic [15:0] val, input logic [15:0] idx);
      plan_row_type row;
      row          = '{default: '0};
      row.pkt      = make_setup(rt, rq, val, idx);
      plan.push_back(row);
   endfunction

   function automatic void plan_pinned(input logic [7:0] rt, input logic [7:0] rq,
                                       input logic [15:0] val, input logic [15:0] idx,
                                       input usbreq_pkg::result_type want);
      plan_row_type row;
      row        = '{default: '0};
      row.pkt    = make_setup(rt, rq, val, idx);
      row.pinned = 1'b1;
      row.want   = want;
      plan.push_back(row);
   endfunction

   function automatic void plan_write(input logic [usbreq_pkg::CSR_ADDR_W-1:0] idx,
                                      input logic [usbreq_pkg::CSR_DATA_W-1:0] val);
      plan_row_type row;
      row          = '{default: '0};
      row.is_write = 1'b1;
      row.reg_idx  = idx;
      row.reg_val  = val;
      plan.push_back(row);
   endfunction

   // Mostly back-to-back, now and then a few cycles, rarely a long gap.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // An endpoint number in wIndex: usually just around the valid range, with the
   // high byte sometimes filled in, otherwise anything at all.
   function automatic logic [15:0] pick_endpoint();
      logic [15:0] idx;
      idx = 16'($urandom);
      if ($urandom_range(0, 4) != 0) begin
         idx[7:0] = 8'($urandom_range(0, usbreq_pkg::NUM_ENDPOINTS + 1));
         if ($urandom_range(0, 1) == 0)
            idx[15:8] = 8'h00;
      end
      return idx;
   endfunction

   // Random setup items. Most are well formed standard requests with random content,
   // so that the descriptor lookup, the halt bits and the stored settings are all
   // exercised; a share is pure noise.
   function automatic usbreq_pkg::setup_type random_setup();
      usbreq_pkg::setup_type s;
      int                    pick;
      int                    choice;
      s    = make_setup(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         s = make_setup(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      end else if (pick < 32) begin
         s.req_type       = usbreq_pkg::RQ_GET_DESCRIPTOR;
         s.recipient_type = ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                                         : usbreq_pkg::RECIP_DEVICE_IN;
         choice = $urandom_range(0, 9);
         if (choice < 7)
            s.setup_value[15:8] = usbreq_pkg::DESC_STRING;
         else if (choice == 7)
            s.setup_value[15:8] = usbreq_pkg::DESC_DEVICE;
         else if (choice == 8)
            s.setup_value[15:8] = usbreq_pkg::DESC_CONFIG;
         else
            s.setup_value[15:8] = 8'($urandom);
         if ($urandom_range(0, 4) != 0)
            s.setup_value[7:0] = 8'($urandom_range(0, usbreq_pkg::NUM_STRINGS + 1));
         choice = $urandom_range(0, 9);
         if (choice < 4)
            s.setup_index = cfg_lang_first;
         else if (choice < 7)
            s.setup_index = cfg_lang_second;
         else if (choice == 7)
            s.setup_index = 16'h0409;
      end else if (pick < 44) begin
         s.req_type = usbreq_pkg::RQ_GET_STATUS;
         choice = $urandom_range(0, 9);
         if (choice < 5)
            s.recipient_type = usbreq_pkg::RECIP_ENDPOINT_IN;
         else if (choice < 7)
            s.recipient_type = usbreq_pkg::RECIP_DEVICE_IN;
         else if (choice < 9)
            s.recipient_type = usbreq_pkg::RECIP_INTERFACE_IN;
         s.setup_index = pick_endpoint();
      end else if (pick < 62) begin
         s.req_type = ($urandom_range(0, 1) == 0) ? usbreq_pkg::RQ_SET_FEATURE
                                                  : usbreq_pkg::RQ_CLEAR_FEATURE;
         if ($urandom_range(0, 6) != 0)
            s.setup_value[7:0] = usbreq_pkg::FEATURE_EP_HALT;
         s.setup_index = pick_endpoint();
      end else if (pick < 70) begin
         s.req_type = usbreq_pkg::RQ_SET_CONFIG;
      end else if (pick < 76) begin
         s.req_type = usbreq_pkg::RQ_GET_CONFIG;
      end else if (pick < 84) begin
         s.req_type = usbreq_pkg::RQ_SET_INTERFACE;
      end else if (pick < 90) begin
         s.req_type = usbreq_pkg::RQ_GET_INTERFACE;
      end
      // The rest keep their random request code: vendor and unsupported requests.
      return s;
   endfunction

   // Offers one setup item and holds it until the handler takes it. Afterwards the
   // valid is dropped only if a gap follows, so that a back-to-back item never sees
   // the valid lowered and raised within one step.
   task automatic offer_setup(input usbreq_pkg::setup_type s, input bit pinned,
                              input usbreq_pkg::result_type want);
      answer_note_type note;
      int              gap;
      note.pinned = pinned;
      note.want   = want;
      notes_q.push_back(note);
      req_tvalid <= 1'b1;
      req_tdata  <= {s.setup_index, s.setup_value, s.req_type, s.recipient_type};
      do
         @(posedge clock);
      while (!req_tready);
      items_sent++;
      gap = steady_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Register writes only go in while the handler is idle: every result back, plus a
   // short pause that covers its two-stage pipeline.
   task automatic write_register(input logic [usbreq_pkg::CSR_ADDR_W-1:0] idx,
                                 input logic [usbreq_pkg::CSR_DATA_W-1:0] val);
      req_tvalid <= 1'b0;
      while (results_seen != items_sent)
         @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         usbreq_pkg::CSR_LANG_COUNT:  cfg_lang_count  = val[1:0];
         usbreq_pkg::CSR_LANG_FIRST:  cfg_lang_first  = val;
         usbreq_pkg::CSR_LANG_SECOND: cfg_lang_second = val;
         usbreq_pkg::CSR_STRING_MASK: cfg_string_mask = val[usbreq_pkg::MASK_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         run_failed = 1'b1;
      end
   endtask

   // Scoreboard. Both channels are sampled at the rising edge, so the values seen are
   // those that were settled before it. An accepted setup item is run through the
   // device model at once; its answer joins the queue unless the plan pinned one.
   always @(posedge clock) begin : scoreboard
      usbreq_pkg::setup_type  seen;
      usbreq_pkg::result_type guess;
      usbreq_pkg::result_type got;
      usbreq_pkg::result_type want;
      answer_note_type        note;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen  = make_setup(req_tdata[7:0], req_tdata[15:8], req_tdata[31:16],
                               req_tdata[47:32]);
            guess = predict_answer(seen);
            note  = notes_q.pop_front();
            answers_due.push_back(note.pinned ? note.want : guess);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.action          = rsp_tdata[1:0];
            got.byte_count      = rsp_tdata[3:2];
            got.data_first      = rsp_tdata[11:4];
            got.data_second     = rsp_tdata[19:12];
            got.descriptor_kind = rsp_tdata[21:20];
            got.string_lang     = rsp_tdata[22];
            got.string_number   = rsp_tdata[24:23];
            if (answers_due.size() == 0) begin
               $display("%0t: result item with none expected, expected nothing, actual %0h",
                        $time, rsp_tdata);
               run_failed = 1'b1;
            end else begin
               want = answers_due.pop_front();
               check_field("action", want.action, got.action);
               check_field("byte_count", want.byte_count, got.byte_count);
               check_field("data_first", want.data_first, got.data_first);
               check_field("data_second", want.data_second, got.data_second);
               check_field("descriptor_kind", want.descriptor_kind, got.descriptor_kind);
               check_field("string_lang", want.string_lang, got.string_lang);
               check_field("string_number", want.string_number, got.string_number);
            end
            results_seen++;
         end
      end
   end

   // Result receiver. It stalls at random, runs flat out when asked, and once holds
   // off for a long stretch so that the handler fills up and stalls its input.
   initial begin
      int stall_len;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (steady_receiver || $urandom_range(0, 99) < 65) begin
            rsp_tready <= 1'b1;
         end else begin
            stall_len = pick_gap();
            rsp_tready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   // Main sequence: reset, the directed plan, then randomised rounds, each under its
   // own register settings.
   initial begin
      logic [15:0] count_val;
      logic [15:0] first_val;
      logic [15:0] second_val;
      logic [15:0] mask_val;
      int          round;
      int          n;
      items_sent       = 0;
      results_seen     = 0;
      run_failed       = 1'b0;
      steady_sender    = 1'b0;
      steady_receiver  = 1'b0;
      hold_off_request = 1'b0;
      cfg_lang_count   = 2'd1;
      cfg_lang_first   = 16'd1033;
      cfg_lang_second  = 16'd0;
      cfg_string_mask  = 8'hFF;
      dev_config       = 8'd0;
      dev_alt          = 8'd0;
      ep_halted        = '0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Straight after reset everything reads back as zero.
      plan_pinned(usbreq_pkg::RECIP_DEVICE_IN, usbreq_pkg::RQ_GET_CONFIG, 16'h0000,
                  16'h0000,
                  plain_answer(usbreq_pkg::ACT_DATA, 2'd1, usbreq_pkg::KIND_DEVICE));
      plan_pinned(usbreq_pkg::RECIP_DEVICE_IN, usbreq_pkg::RQ_GET_STATUS, 16'h0000,
                  16'h0000,
                  plain_answer(usbreq_pkg::ACT_DATA, 2'd2, usbreq_pkg::KIND_DEVICE));
      // Every input bit low: get status to an unknown recipient, plain acknowledge.
      plan_pinned(8'h00, usbreq_pkg::RQ_GET_STATUS, 16'h0000, 16'h0000,
                  plain_answer(usbreq_pkg::ACT_ACK, 2'd0, usbreq_pkg::KIND_DEVICE));
      // Halt an endpoint, read it back, then the top endpoint with a busy high byte.
      plan_pinned(8'h02, usbreq_pkg::RQ_SET_FEATURE, 16'h0000, 16'h0005,
                  plain_answer(usbreq_pkg::ACT_ACK, 2'd0, usbreq_pkg::KIND_DEVICE));
      plan_setup(usbreq_pkg::RECIP_ENDPOINT_IN, usbreq_pkg::RQ_GET_STATUS, 16'h0000,
                 16'h0005);
      plan_setup(8'h02, usbreq_pkg::RQ_SET_FEATURE, 16'hFF00, 16'hFF0F);
      plan_setup(usbreq_pkg::RECIP_ENDPOINT_IN, usbreq_pkg::RQ_GET_STATUS, 16'h0000,
                 16'h000F);
      // The first endpoint out of range is acknowledged but never halted.
      plan_setup(8'h02, usbreq_pkg::RQ_SET_FEATURE, 16'h0000, 16'h0010);
      plan_setup(usbreq_pkg::RECIP_ENDPOINT_IN, usbreq_pkg::RQ_GET_STATUS, 16'h0000,
                 16'h0010);
      // Feature selectors other than endpoint halt stall.
      plan_pinned(8'h00, usbreq_pkg::RQ_SET_FEATURE, 16'h0001, 16'h0000,
                  plain_answer(usbreq_pkg::ACT_STALL, 2'd0, usbreq_pkg::KIND_DEVICE));
      plan_pinned(8'h02, usbreq_pkg::RQ_CLEAR_FEATURE, 16'h00FF, 16'h0005,
                  plain_answer(usbreq_pkg::ACT_STALL, 2'd0, usbreq_pkg::KIND_DEVICE));
      plan_setup(8'h02, usbreq_pkg::RQ_CLEAR_FEATURE, 16'h0000, 16'h0005);
      // Wide values keep only their low byte.
      plan_setup(8'h00, usbreq_pkg::RQ_SET_CONFIG, 16'hFFFF, 16'h0000);
      plan_setup(usbreq_pkg::RECIP_DEVICE_IN, usbreq_pkg::RQ_GET_CONFIG, 16'h0000,
                 16'h0000);
      plan_setup(8'h01, usbreq_pkg::RQ_SET_INTERFACE, 16'hAB12, 16'h0000);
      plan_setup(usbreq_pkg::RECIP_INTERFACE_IN, usbreq_pkg::RQ_GET_INTERFACE, 16'h0000,
                 16'h0000);
      // Descriptors: device, configuration, unknown types.
      plan_pinned(usbreq_pkg::RECIP_DEVICE_IN, usbreq_pkg::RQ_GET_DESCRIPTOR, 16'h0100,
                  16'h0000,
                  plain_answer(usbreq_pkg::ACT_DESC, 2'd0, usbreq_pkg::KIND_DEVICE));
      plan_pinned(usbreq_pkg::RECIP_DEVICE_IN, usbreq_pkg::RQ_GET_DESCRIPTOR, 16'h02FF,
                  16'hFFFF,
                  plain_answer(usbreq_pkg::ACT_DESC, 2'd0, usbreq_pkg::KIND_CONFIG));
      plan_pinned(usbreq_pkg::RECIP_DEVICE_IN, usbreq_pkg::RQ_GET_DESCRIPTOR, 16'hFF00,
                  16'h0000,
                  plain_answer(usbreq_pkg::ACT_STALL, 2'd0, usbreq_pkg::KIND_DEVICE));
      // String zero ignores wIndex; other strings need a listed language.
      plan_setup(usbreq_pkg::RECIP_DEVICE_IN, usbreq_pkg::RQ_GET_DESCRIPTOR, 16'h0300,
                 16'hFFFF);
      plan_setup(usbreq_pkg::RECIP_DEVICE_IN, usbreq_pkg::RQ_GET_DESCRIPTOR, 16'h0301,
                 16'h0409);
      plan_pinned(usbreq_pkg::RECIP_DEVICE_IN, usbreq_pkg::RQ_GET_DESCRIPTOR, 16'h0304,
                  16'h0409,
                  plain_answer(usbreq_pkg::ACT_STALL, 2'd0, usbreq_pkg::KIND_DEVICE));
      plan_pinned(usbreq_pkg::RECIP_DEVICE_IN, usbreq_pkg::RQ_GET_DESCRIPTOR, 16'h0301,
                  16'h0000,
                  plain_answer(usbreq_pkg::ACT_STALL, 2'd0, usbreq_pkg::KIND_DEVICE));
      // Every input bit high: an unknown request, acknowledged as a vendor request.
      plan_pinned(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                  plain_answer(usbreq_pkg::ACT_ACK, 2'd0, usbreq_pkg::KIND_DEVICE));
      // Two languages with a sparse presence mask.
      plan_write(usbreq_pkg::CSR_LANG_COUNT, 16'h0002);
      plan_write(usbreq_pkg::CSR_LANG_SECOND, 16'h0407);
      plan_write(usbreq_pkg::CSR_STRING_MASK, 16'h005A);
      plan_setup(usbreq_pkg::RECIP_DEVICE_IN, usbreq_pkg::RQ_GET_DESCRIPTOR, 16'h0302,
                 16'h0409);
      plan_setup(usbreq_pkg::RECIP_DEVICE_IN, usbreq_pkg::RQ_GET_DESCRIPTOR, 16'h0302,
                 16'h0407);
      // A count of three with both IDs equal: the first slot wins.
      plan_write(usbreq_pkg::CSR_LANG_COUNT, 16'hFFFF);
      plan_write(usbreq_pkg::CSR_LANG_FIRST, 16'hFFFF);
      plan_write(usbreq_pkg::CSR_LANG_SECOND, 16'hFFFF);
      plan_write(usbreq_pkg::CSR_STRING_MASK, 16'h00FF);
      plan_setup(usbreq_pkg::RECIP_DEVICE_IN, usbreq_pkg::RQ_GET_DESCRIPTOR, 16'h0303,
                 16'hFFFF);
      // No languages listed: every string but string zero stalls.
      plan_write(usbreq_pkg::CSR_LANG_COUNT, 16'h0000);
      plan_setup(usbreq_pkg::RECIP_DEVICE_IN, usbreq_pkg::RQ_GET_DESCRIPTOR, 16'h0301,
                 16'hFFFF);

      foreach (plan[i]) begin
         if (plan[i].is_write)
            write_register(plan[i].reg_idx, plan[i].reg_val);
         else
            offer_setup(plan[i].pkt, plan[i].pinned, plan[i].want);
      end

      // Random rounds. The first few use extreme settings; round four is the long
      // hold-off with the sender running flat out, round five has no idling at all.
      for (round = 0; round < 8; round++) begin
         case (round)
            0: begin
               count_val  = 16'h0002;
               first_val  = 16'($urandom);
               second_val = 16'($urandom);
               mask_val   = 16'($urandom);
            end
            1: begin
               count_val  = 16'h0000;
               first_val  = 16'h0000;
               second_val = 16'h0000;
               mask_val   = 16'h0000;
            end
            2: begin
               count_val  = 16'hFFFF;
               first_val  = 16'hFFFF;
               second_val = 16'hFFFF;
               mask_val   = 16'hFFFF;
            end
            3: begin
               count_val  = 16'h0001;
               first_val  = 16'h0409;
               second_val = 16'($urandom);
               mask_val   = 16'($urandom);
            end
            default: begin
               count_val  = 16'($urandom);
               first_val  = 16'($urandom);
               second_val = ($urandom_range(0, 3) == 0) ? first_val : 16'($urandom);
               mask_val   = 16'($urandom);
            end
         endcase
         write_register(usbreq_pkg::CSR_LANG_COUNT, count_val);
         write_register(usbreq_pkg::CSR_LANG_FIRST, first_val);
         write_register(usbreq_pkg::CSR_LANG_SECOND, second_val);
         write_register(usbreq_pkg::CSR_STRING_MASK, mask_val);
         steady_sender    = (round == 4 || round == 5);
         steady_receiver  = (round == 5);
         hold_off_request = (round == 4);
         for (n = 0; n < 104; n++)
            offer_setup(random_setup(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      // Drain, then give any stray result time to show up.
      while (results_seen != items_sent)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (answers_due.size() != 0) begin
         $display("%0t: results outstanding, expected 0, actual %0d", $time,
                  answers_due.size());
         run_failed = 1'b1;
      end
      if (!run_failed)
         $display("usb_standard_request_handler verification clean");
      else
         $display("usb_standard_request_handler verification failed");
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("usb_standard_request_handler verification failed");
      $finish;
   end

endmodule
